/* sv/bbs_pkg.sv */
`default_nettype none

package bbs_pkg;

  localparam int IDX_W     = 6;
  localparam int SIZE_IN_W = 31;
  localparam int ALIGN_W   = 5;
  localparam int MASK_W    = 32;
  localparam int OFF_W     = 32;
  localparam int CFG_W     = 32;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_W-1:0] DEF_CAP_RST = 32'd16777216;

  // Result kinds.
  localparam logic [1:0] RES_GRANT = 2'd0;
  localparam logic [1:0] RES_NEW   = 2'd1;
  localparam logic [1:0] RES_FULL  = 2'd2;

  typedef struct packed {
    logic             load_req;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             open_calc;
    logic             wr_hit;
    logic             wr_new;
    logic [IDX_W-1:0] new_idx;
    logic             out_load;
    logic [1:0]       res_kind;
  } bbs_cmd_t;

  typedef struct packed {
    logic hit;
    logic busy;
  } bbs_sts_t;

endpackage

`default_nettype wire

/* sv/bbs_dp.sv */
`default_nettype none

module bbs_dp import bbs_pkg::*; #(
  parameter int BLOCK_SLOTS = 32,
  parameter int SIZE_BITS   = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire bbs_cmd_t               cmd,
  output bbs_sts_t                    sts,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tuser
);

  localparam int IW    = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
  localparam int EW    = ((SIZE_BITS > 32) ? SIZE_BITS : 32) + 2;
  localparam int ENT_W = MASK_W + 2 * SIZE_BITS;
  localparam logic [EW-1:0] SIZE_MAX = EW'({SIZE_BITS{1'b1}});

  logic [CFG_W-1:0]     def_cap_r;
  logic [SIZE_IN_W-1:0] size_r;
  logic [ALIGN_W-1:0]   alog_r;
  logic [MASK_W-1:0]    mask_r;

  logic [ENT_W-1:0]     mem [BLOCK_SLOTS];
  logic [ENT_W-1:0]     rd_q_r;
  logic [IW-1:0]        rd_idx_r;
  logic                 v_rd_r;
  logic                 v_a_r;

  logic [EW-1:0]        rounded_a_r;
  logic [SIZE_BITS-1:0] cap_a_r;
  logic                 match_a_r;
  logic [IW-1:0]        idx_a_r;

  logic [IW-1:0]        g_idx_r;
  logic [OFF_W-1:0]     g_off_r;
  logic [SIZE_BITS-1:0] g_used_r;
  logic [SIZE_BITS-1:0] g_cap_r;
  logic [SIZE_BITS-1:0] nc_cap_r;

  logic                 status_r;
  logic [IDX_W-1:0]     idx_r;
  logic [OFF_W-1:0]     off_r;
  logic                 new_r;

  logic [EW-1:0]        align_w;
  logic [EW-1:0]        align_m1;
  logic [MASK_W-1:0]    q_type;
  logic [SIZE_BITS-1:0] q_cap;
  logic [SIZE_BITS-1:0] q_used;
  logic [EW-1:0]        end_sum;
  logic                 hit;
  logic [EW-1:0]        need_sum;
  logic [EW-1:0]        cap_pre;
  logic [SIZE_BITS-1:0] new_used;

  always_comb begin
    align_w  = EW'(1) << alog_r;
    align_m1 = align_w - EW'(1);
    q_type   = rd_q_r[ENT_W-1 -: MASK_W];
    q_cap    = rd_q_r[2*SIZE_BITS-1 -: SIZE_BITS];
    q_used   = rd_q_r[SIZE_BITS-1:0];
    end_sum  = rounded_a_r + EW'(size_r);
    hit      = v_a_r & match_a_r & (end_sum <= EW'(cap_a_r));
    need_sum = EW'(size_r) + align_w;
    cap_pre  = (EW'(def_cap_r) < need_sum) ? need_sum : EW'(def_cap_r);
    new_used = (EW'(size_r) < EW'(nc_cap_r)) ? SIZE_BITS'(size_r) : nc_cap_r;
  end

  assign sts.hit  = hit;
  assign sts.busy = v_rd_r | v_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_cap_r <= DEF_CAP_RST;
      v_rd_r    <= 1'b0;
      v_a_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        def_cap_r <= cfg_data;
      end
      // A hit stops the scan, so reads still in flight are dropped.
      v_rd_r <= cmd.rd_en & ~hit;
      v_a_r  <= v_rd_r & ~hit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      size_r <= in_tdata[30:0];
      alog_r <= in_tdata[35:31];
      mask_r <= in_tdata[67:36];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_hit) begin
      mem[g_idx_r] <= {mask_r, g_cap_r, g_used_r};
    end else if (cmd.wr_new) begin
      mem[cmd.new_idx[IW-1:0]] <= {mask_r, nc_cap_r, new_used};
    end
    if (cmd.rd_en) begin
      rd_q_r   <= mem[cmd.rd_addr[IW-1:0]];
      rd_idx_r <= cmd.rd_addr[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rounded_a_r <= (EW'(q_used) + align_m1) & ~align_m1;
    cap_a_r     <= q_cap;
    match_a_r   <= (q_type == mask_r);
    idx_a_r     <= rd_idx_r;
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      g_idx_r  <= idx_a_r;
      g_off_r  <= rounded_a_r[OFF_W-1:0];
      g_used_r <= end_sum[SIZE_BITS-1:0];
      g_cap_r  <= cap_a_r;
    end else if (cmd.wr_new) begin
      g_idx_r <= cmd.new_idx[IW-1:0];
      g_off_r <= '0;
    end
    if (cmd.open_calc) begin
      nc_cap_r <= (cap_pre > SIZE_MAX) ? SIZE_MAX[SIZE_BITS-1:0] : cap_pre[SIZE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.res_kind)
        RES_GRANT: begin
          status_r <= 1'b0;
          idx_r    <= IDX_W'(g_idx_r);
          off_r    <= g_off_r;
          new_r    <= 1'b0;
        end
        RES_NEW: begin
          status_r <= 1'b0;
          idx_r    <= IDX_W'(g_idx_r);
          off_r    <= g_off_r;
          new_r    <= 1'b1;
        end
        default: begin
          status_r <= 1'b1;
          idx_r    <= '0;
          off_r    <= '0;
          new_r    <= 1'b0;
        end
      endcase
    end
  end

  assign out_tdata = {1'b0, new_r, off_r, idx_r};
  assign out_tuser = status_r;

endmodule

`default_nettype wire

/* sv/bbs_ctrl.sv */
`default_nettype none

module bbs_ctrl import bbs_pkg::*; #(
  parameter int BLOCK_SLOTS = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  input  wire bbs_sts_t sts,
  output bbs_cmd_t      cmd
);

  localparam int CW = $clog2(BLOCK_SLOTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_OPEN  = 3'd2;
  localparam logic [2:0] S_WRNEW = 3'd3;
  localparam logic [2:0] S_WRHIT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] open_r, open_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic          out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    open_nxt      = open_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    cmd           = '0;
    cmd.rd_addr   = IDX_W'(cnt_r);
    cmd.new_idx   = IDX_W'(open_r);
    cmd.res_kind  = kind_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_en = (cnt_r < open_r) && !sts.hit;
        if (cmd.rd_en) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        if (sts.hit) begin
          kind_nxt  = RES_GRANT;
          state_nxt = S_WRHIT;
        end else if ((cnt_r == open_r) && !sts.busy) begin
          if (open_r == CW'(BLOCK_SLOTS)) begin
            kind_nxt  = RES_FULL;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_OPEN;
          end
        end
      end
      S_OPEN: begin
        cmd.open_calc = 1'b1;
        state_nxt     = S_WRNEW;
      end
      S_WRNEW: begin
        cmd.wr_new = 1'b1;
        open_nxt   = open_r + CW'(1);
        kind_nxt   = RES_NEW;
        state_nxt  = S_DONE;
      end
      S_WRHIT: begin
        cmd.wr_hit = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        // Wait here only while the previous result is still held.
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      open_r      <= '0;
      kind_r      <= RES_GRANT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      open_r      <= open_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/block_bump_suballocator.sv */
// Channel   Ports                       Payload
// in        in_tvalid/in_tready/in_*    request_size, align_log2, type_mask
// out       out_tvalid/out_tready/out_* status, block_index, grant_offset, opened_new
// cfg       cfg_valid/cfg_ready         default_block_capacity
//
// One request at a time. The block table is scanned from entry 0, one read per cycle,
// through a two-stage read and compare pipeline. A grant, a newly opened block or a no-room
// answer is offered in the cycle in which in_tready rises again. Reset empties the table
// and restores the default capacity of 16777216. A result held on a stalled output only
// delays the next result.
`default_nettype none

module block_bump_suballocator import bbs_pkg::*; #(
  parameter int BLOCK_SLOTS = 32,
  parameter int SIZE_BITS   = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // request_size [30:0], align_log2 [35:31], type_mask [67:36], zeros [71:68]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // block_index [5:0], grant_offset [37:6], opened_new [38], zero [39]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // status [0]
  output logic                        out_tuser
);

  bbs_cmd_t cmd;
  bbs_sts_t sts;

  assign cfg_ready = 1'b1;

  bbs_ctrl #(
    .BLOCK_SLOTS (BLOCK_SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  bbs_dp #(
    .BLOCK_SLOTS (BLOCK_SLOTS),
    .SIZE_BITS   (SIZE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

`default_nettype wire

/* sv/bbs_checker.sv */
`default_nettype none

module bbs_checker import bbs_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic [OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                   out_tuser
);

  // A held result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // Requests are served one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one is in progress");

  // A no-room answer carries no block, offset or new-block mark.
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata == '0))
    else $error("no-room result with payload");

  // A freshly opened block always grants from its start.
  a_new_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[38] |-> (out_tdata[37:6] == '0) && !out_tuser)
    else $error("new block granted at non-zero offset");

endmodule

bind block_bump_suballocator bbs_checker u_bbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
